// ----- hw/rtl/ima_pkg.sv -----
// Package for the IMA ADPCM decoder: payload structs, config register
// indexes, the step size table and the per-nibble decode function.
// No dependencies.
`default_nettype none

package ima_pkg;

  localparam int VOL_SHIFT = 6;
  localparam int OUT_SHIFT = 16 - (8 + VOL_SHIFT);
  localparam int MAX_INDEX = 88;
  localparam int STEP_W    = 15;
  localparam int IDX_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [IDX_W-1:0] MAX_INDEX_V = IDX_W'(MAX_INDEX);

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SAMPLE = 2'd1;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] pred;
  } dec_state_t;

  localparam logic [STEP_W-1:0] STEP_TABLE [0:MAX_INDEX] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  function automatic logic [IDX_W-1:0] clamp_index(logic [IDX_W-1:0] idx);
    return (idx > MAX_INDEX_V) ? MAX_INDEX_V : idx;
  endfunction

  function automatic logic [STEP_W-1:0] step_lookup(logic [IDX_W-1:0] idx);
    return STEP_TABLE[clamp_index(idx)];
  endfunction

  // One nibble: step lookup, shift-add difference, saturating update, index move.
  function automatic dec_state_t decode_nib(dec_state_t cur, logic [3:0] nib);
    logic [STEP_W-1:0]  step;
    logic [18:0]        prod;
    logic [15:0]        diff;
    logic signed [17:0] pred_x;
    logic signed [17:0] sum;
    logic [2:0]         up;
    logic [IDX_W-1:0]   idx_up;
    dec_state_t         res;
    step = step_lookup(cur.idx);
    // step*(2m+1) as a sum of shifted copies
    prod = {4'b0, step}
         + (nib[0] ? {3'b0, step, 1'b0} : 19'd0)
         + (nib[1] ? {2'b0, step, 2'b0} : 19'd0)
         + (nib[2] ? {1'b0, step, 3'b0} : 19'd0);
    diff = prod[18:3];
    pred_x = $signed({{2{cur.pred[15]}}, cur.pred});
    if (nib[3]) begin
      sum = pred_x - $signed({2'b00, diff});
    end else begin
      sum = pred_x + $signed({2'b00, diff});
    end
    if (sum[17:15] != 3'b000 && sum[17:15] != 3'b111) begin
      res.pred = sum[17] ? 16'sh8000 : 16'sh7fff;
    end else begin
      res.pred = sum[15:0];
    end
    up = {1'b0, nib[1:0]} + 3'd1;
    idx_up = cur.idx + {3'b000, up, 1'b0};
    if (!nib[2]) begin
      res.idx = (cur.idx == '0) ? '0 : cur.idx - IDX_W'(1);
    end else begin
      res.idx = clamp_index(idx_up);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ima_adpcm_decoder.sv -----
// IMA ADPCM decoder: one code byte in, two scaled 16-bit samples out.
// out_valid rises in the cycle after input accept; throughput 1 item per cycle unless out_stall holds a result.
// The state path (two chained nibble updates: step table lookup, shift-add,
// saturating add) runs between the state registers and the result register.
// Synchronous active-low reset clears state, config registers and out_valid.
// Depends on ima_pkg.
`default_nettype none

module ima_adpcm_decoder import ima_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  dec_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   start_index_r, start_index_nxt;
  logic signed [15:0] start_sample_r, start_sample_nxt;

  logic       in_acc;
  logic       cfg_acc;
  dec_state_t st0, st1, st2;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (in_data.restart) begin
      st0.idx  = clamp_index(start_index_r);
      st0.pred = start_sample_r;
    end else begin
      st0 = state_r;
    end
    st1 = decode_nib(st0, in_data.code_byte[3:0]);
    st2 = decode_nib(st1, in_data.code_byte[7:4]);
  end

  always_comb begin
    start_index_nxt  = start_index_r;
    start_sample_nxt = start_sample_r;
    if (cfg_acc) begin
      case (cfg_index)
        CFG_START_INDEX:  start_index_nxt  = cfg_data[IDX_W-1:0];
        CFG_START_SAMPLE: start_sample_nxt = cfg_data;
        default: ;
      endcase
    end
    state_nxt     = state_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc) begin
      state_nxt                  = st2;
      out_data_nxt.sample_first  = st1.pred >>> OUT_SHIFT;
      out_data_nxt.sample_second = st2.pred >>> OUT_SHIFT;
      out_valid_nxt              = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      state_r        <= '0;
      start_index_r  <= '0;
      start_sample_r <= '0;
    end else begin
      out_valid_r    <= out_valid_nxt;
      state_r        <= state_nxt;
      start_index_r  <= start_index_nxt;
      start_sample_r <= start_sample_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.idx <= MAX_INDEX_V)
    else $error("step index left table range");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_drain_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !in_acc) |=> !out_valid_r)
    else $error("result repeated after it was taken");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(state_r))
    else $error("decoder state moved without an item");

endmodule

`default_nettype wire
